### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access package
// Beat types, configuration register indexes and action codes shared by the
// sequencer, the configuration registers and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PHASE_TICKS    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_ACK_TIMEOUT    = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd25;
  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RESET    = 8'd250;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

endpackage

### rtl/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// I2C master configuration registers
// Holds the target address, the phase length and the acknowledge timeout,
// written one register per beat of the configuration channel.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [i2cm_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  output i2cm_pkg::cfg_t                       cfg_o
);
  import i2cm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS: cfg_d.device_address = cfg_data_i[6:0];
        CFG_PHASE_TICKS:    cfg_d.phase_ticks    = cfg_data_i;
        CFG_ACK_TIMEOUT:    cfg_d.ack_timeout    = cfg_data_i[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= DEVICE_ADDRESS_RESET;
      cfg_q.phase_ticks    <= PHASE_TICKS_RESET;
      cfg_q.ack_timeout    <= ACK_TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/i2cm_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Advances the bus sequence by one tick per step and produces the line levels
// and status that follow from the new state.
// ----------------------------------------------------------------------------
module i2cm_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2cm_pkg::in_t  item_i,
  input  i2cm_pkg::cfg_t cfg_i,
  output i2cm_pkg::out_t res_o
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_TX0, PH_TX1, PH_TX2, PH_TX3,
    PH_AK0, PH_AK1, PH_AKW, PH_RX0, PH_RX1, PH_RX2, PH_RX3,
    PH_NK0, PH_NK1, PH_NK2, PH_NK3, PH_SP0, PH_SP1, PH_SP2
  } phase_e;

  typedef enum logic [1:0] {
    STAGE_ADDR, STAGE_REG, STAGE_DATA, STAGE_READ
  } stage_e;

  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  wait_q, wait_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  held_reg_q, held_reg_d;
  logic [7:0]  held_data_q, held_data_d;
  logic [7:0]  rx_q, rx_d;
  logic        err_q, err_d;
  stage_e      stage_q, stage_d;

  logic [15:0] tick_inc;
  logic [15:0] tick_lim;
  logic [3:0]  bit_inc;
  logic        done;
  logic        scl;
  logic        sda;

  assign tick_inc = tick_q + 16'd1;
  assign tick_lim = (cfg_i.phase_ticks == '0) ? 16'd1 : cfg_i.phase_ticks;
  assign bit_inc  = bit_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    is_read_d   = is_read_q;
    held_reg_d  = held_reg_q;
    held_data_d = held_data_q;
    rx_d        = rx_q;
    err_d       = err_q;
    stage_d     = stage_q;
    done        = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.action == ACT_WRITE || item_i.action == ACT_READ) begin
        is_read_d   = (item_i.action == ACT_READ);
        held_reg_d  = item_i.target_reg;
        held_data_d = item_i.write_data;
        err_d       = 1'b0;
        stage_d     = STAGE_ADDR;
        bit_d       = '0;
        wait_d      = '0;
        phase_d     = PH_ST1;
        tick_d      = '0;
      end
    end else if (phase_q == PH_AKW) begin
      if (!item_i.sda_in) begin
        tick_d = '0;
        case (stage_q)
          STAGE_ADDR: begin
            stage_d = STAGE_REG;
            shift_d = held_reg_q;
            bit_d   = '0;
            phase_d = PH_TX0;
          end
          STAGE_REG: begin
            if (is_read_q) begin
              stage_d = STAGE_READ;
              phase_d = PH_ST0;
            end else begin
              stage_d = STAGE_DATA;
              shift_d = held_data_q;
              bit_d   = '0;
              phase_d = PH_TX0;
            end
          end
          STAGE_DATA: phase_d = PH_SP0;
          default: begin
            bit_d   = '0;
            shift_d = '0;
            phase_d = PH_RX0;
          end
        endcase
      end else if (wait_q >= cfg_i.ack_timeout) begin
        err_d   = 1'b1;
        phase_d = PH_SP0;
        tick_d  = '0;
      end else begin
        wait_d = wait_q + 8'd1;
      end
    end else if (tick_inc < tick_lim) begin
      tick_d = tick_inc;
    end else begin
      tick_d = '0;
      case (phase_q)
        PH_ST0: phase_d = PH_ST1;
        PH_ST1: phase_d = PH_ST2;
        PH_ST2: begin
          shift_d = {cfg_i.device_address, (stage_q == STAGE_READ)};
          bit_d   = '0;
          phase_d = PH_TX0;
        end
        PH_TX0: phase_d = PH_TX1;
        PH_TX1: phase_d = PH_TX2;
        PH_TX2: phase_d = PH_TX3;
        PH_TX3: begin
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            bit_d   = '0;
            phase_d = PH_AK0;
          end else begin
            bit_d   = bit_inc;
            phase_d = PH_TX0;
          end
        end
        PH_AK0: phase_d = PH_AK1;
        PH_AK1: begin
          wait_d  = '0;
          phase_d = PH_AKW;
        end
        PH_RX0: phase_d = PH_RX1;
        PH_RX1: phase_d = PH_RX2;
        PH_RX2: begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          phase_d = PH_RX3;
        end
        PH_RX3: begin
          if (bit_inc >= 4'd8) begin
            bit_d   = '0;
            rx_d    = shift_q;
            phase_d = PH_NK0;
          end else begin
            bit_d   = bit_inc;
            phase_d = PH_RX0;
          end
        end
        PH_NK0: phase_d = PH_NK1;
        PH_NK1: phase_d = PH_NK2;
        PH_NK2: phase_d = PH_NK3;
        PH_NK3: phase_d = PH_SP0;
        PH_SP0: phase_d = PH_SP1;
        PH_SP1: phase_d = PH_SP2;
        default: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    case (phase_d)
      PH_ST0: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      PH_ST2: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      PH_TX0, PH_TX1: begin
        scl = 1'b0;
        sda = shift_d[7];
      end
      PH_TX2, PH_TX3: begin
        scl = 1'b1;
        sda = shift_d[7];
      end
      PH_AK0, PH_RX0, PH_RX1, PH_NK0, PH_NK1: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      PH_SP0: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_SP1: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase
  end

  assign res_o.scl_out   = scl;
  assign res_o.sda_out   = sda;
  assign res_o.busy_res  = (phase_d != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.read_data = rx_d;
  assign res_o.ack_error = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      wait_q      <= '0;
      is_read_q   <= 1'b0;
      held_reg_q  <= '0;
      held_data_q <= '0;
      rx_q        <= '0;
      err_q       <= 1'b0;
      stage_q     <= STAGE_ADDR;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      wait_q      <= wait_d;
      is_read_q   <= is_read_d;
      held_reg_q  <= held_reg_d;
      held_data_q <= held_data_d;
      rx_q        <= rx_d;
      err_q       <= err_d;
      stage_q     <= stage_d;
    end
  end

  a_done_from_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && done) |-> (phase_q == PH_SP2))
    else $error("Transaction ended from a phase other than the last stop phase.");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q < 4'd8)
    else $error("Bit counter left its range.");

  a_tick_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_d != phase_q)) |=> (tick_q == '0))
    else $error("Tick counter not cleared on a phase change.");

  a_error_from_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> ($past(phase_q) == PH_AKW))
    else $error("Error flag set outside an acknowledge wait.");

endmodule

### rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access
// Single-register write and read transactions on an I2C bus, one bus tick
// per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the bus: it carries the requested action
// (taken only while idle), the register address, the write data and the
// sampled data line. Each input beat yields exactly one output beat with the
// driven clock and data levels, busy, a done pulse, the last read byte and
// the acknowledge error flag.
// An accepted beat sits in the input register, the sequencer steps once as it
// moves on, and the result lands in the output register. One beat is taken
// every cycle while the output side keeps up; the sequencer state loop sets
// that. When the receiver stalls, the output register holds its beat, the
// input register fills and input ready drops until the output is taken.
// Configuration beats are taken every cycle and should be sent while idle.
// Reset leaves the sequencer idle and the configuration registers at
// their defaults: address 25, five ticks per phase, timeout 250.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  i2cm_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output i2cm_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [i2cm_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [15:0]                        cfg_data_i
);
  import i2cm_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  logic in_valid_q;
  out_t res;
  out_t out_q;
  logic out_valid_q;
  logic step;

  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;

  i2cm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cm_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
